// ===== rtl/rfd_pkg.sv =====
package rfd_pkg;

  // Ring depth default
  localparam int MAX_CELLS_DEF = 4096;

  // Field widths
  localparam int FOLD_W = 24;
  localparam int EXC_W  = FOLD_W - 1;
  localparam int FOAM_W = 17;
  localparam int IDX_W  = 12;
  localparam int Q_W    = 17;
  localparam int RLEN_W = 13;
  localparam int SPAN_W = 30;
  localparam int GAIN_W = 24;
  localparam int GEN_W  = Q_W + GAIN_W - 16;

  // APB port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;

  // Register reset values
  localparam logic [RLEN_W-1:0] RING_LENGTH_RST = 13'd4096;
  localparam logic [Q_W-1:0]    GEN_THRESHOLD_RST = 17'd0;
  localparam logic [SPAN_W-1:0] INV_SPAN_RST = 30'd65536;
  localparam logic [GAIN_W-1:0] GEN_GAIN_RST = 24'd0;
  localparam logic [Q_W-1:0]    RETENTION_RST = 17'd65536;
  localparam logic [Q_W-1:0]    BLEND_RST = 17'd0;

  typedef enum logic [2:0] {
    REG_RING_LENGTH,
    REG_GEN_THRESHOLD,
    REG_INV_SPAN,
    REG_GEN_GAIN,
    REG_RETENTION,
    REG_BLEND
  } rfd_reg_e;

  typedef struct packed {
    logic [RLEN_W-1:0] ring_length;
    logic [Q_W-1:0]    gen_threshold;
    logic [SPAN_W-1:0] inv_span;
    logic [GAIN_W-1:0] gen_gain;
    logic [Q_W-1:0]    retention;
    logic [Q_W-1:0]    blend;
  } rfd_cfg_t;

  // Saturate a level to one in Q1.16
  function automatic logic [Q_W-1:0] clamp_q16(input logic [63:0] v);
    logic [Q_W-1:0] r;
    r = (v > 64'(ONE_Q16)) ? ONE_Q16 : v[Q_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/rfd_fold_if.sv =====
interface rfd_fold_if;
  logic                              valid;
  logic                              ready;
  logic signed [rfd_pkg::FOLD_W-1:0] fold;

  modport source (output valid, output fold, input ready);
  modport sink   (input valid, input fold, output ready);
endinterface

// ===== rtl/rfd_foam_if.sv =====
interface rfd_foam_if;
  logic                       valid;
  logic                       ready;
  logic [rfd_pkg::FOAM_W-1:0] foam;
  logic [rfd_pkg::IDX_W-1:0]  cell_index;
  logic                       sweep_end;

  modport source (output valid, output foam, output cell_index, output sweep_end, input ready);
  modport sink   (input valid, input foam, input cell_index, input sweep_end, output ready);
endinterface

// ===== rtl/rfd_cfg_regs.sv =====
module rfd_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rfd_pkg::APB_AW-1:0] paddr,
  input  logic [rfd_pkg::APB_DW-1:0] pwdata,
  output logic [rfd_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output rfd_pkg::rfd_cfg_t          cfg_o
);
  import rfd_pkg::*;

  rfd_cfg_t cfg_q;
  rfd_reg_e reg_sel;
  logic     wr_beat;

  assign reg_sel = rfd_reg_e'(paddr[APB_AW-1:2]);
  assign wr_beat = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ring_length   <= RING_LENGTH_RST;
      cfg_q.gen_threshold <= GEN_THRESHOLD_RST;
      cfg_q.inv_span      <= INV_SPAN_RST;
      cfg_q.gen_gain      <= GEN_GAIN_RST;
      cfg_q.retention     <= RETENTION_RST;
      cfg_q.blend         <= BLEND_RST;
    end else if (wr_beat) begin
      case (reg_sel)
        REG_RING_LENGTH:   cfg_q.ring_length   <= pwdata[RLEN_W-1:0];
        REG_GEN_THRESHOLD: cfg_q.gen_threshold <= pwdata[Q_W-1:0];
        REG_INV_SPAN:      cfg_q.inv_span      <= pwdata[SPAN_W-1:0];
        REG_GEN_GAIN:      cfg_q.gen_gain      <= pwdata[GAIN_W-1:0];
        REG_RETENTION:     cfg_q.retention     <= pwdata[Q_W-1:0];
        REG_BLEND:         cfg_q.blend         <= pwdata[Q_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_RING_LENGTH:   prdata = APB_DW'(cfg_q.ring_length);
      REG_GEN_THRESHOLD: prdata = APB_DW'(cfg_q.gen_threshold);
      REG_INV_SPAN:      prdata = APB_DW'(cfg_q.inv_span);
      REG_GEN_GAIN:      prdata = APB_DW'(cfg_q.gen_gain);
      REG_RETENTION:     prdata = APB_DW'(cfg_q.retention);
      REG_BLEND:         prdata = APB_DW'(cfg_q.blend);
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== rtl/rfd_store.sv =====
module rfd_store #(
  parameter int MAX_CELLS = rfd_pkg::MAX_CELLS_DEF,
  parameter int IW        = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [IW-1:0]           rd_a_addr_i,
  input  logic [IW-1:0]           rd_b_addr_i,
  output logic [rfd_pkg::Q_W-1:0] rd_a_data_o,
  output logic [rfd_pkg::Q_W-1:0] rd_b_data_o,
  input  logic                    wr_en_i,
  input  logic [IW-1:0]           wr_addr_i,
  input  logic [rfd_pkg::Q_W-1:0] wr_data_i,
  output logic                    busy_o
);
  import rfd_pkg::*;

  logic [Q_W-1:0] mem_q [MAX_CELLS];
  logic [Q_W-1:0] rd_a_q, rd_b_q;
  logic [IW-1:0]  clr_q;
  logic           busy_q;
  logic           clr_last;

  assign clr_last    = (32'(clr_q) == 32'(MAX_CELLS - 1));
  assign busy_o      = busy_q;
  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

  // Sweep zeros through the store after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      if (clr_last) begin
        busy_q <= 1'b0;
      end
      clr_q <= clr_q + IW'(1);
    end
  end

  // One write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_a_q <= mem_q[rd_a_addr_i];
    rd_b_q <= mem_q[rd_b_addr_i];
  end

  a_no_write_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !wr_en_i)
    else $error("store written during clearing pass");

endmodule

// ===== rtl/ring_foam_decay_diffusion_unit.sv =====
// An accepted fold beat passes through the load, mix, retention and done states to its
// foam beat; cell zero of a ring of three or more cells adds a second load state, for a
// second read of the store for its right side. One cell is in flight at a time, set by
// the read-multiply-multiply-write sequence around the single foam store.
// Reset: a clearing pass zeroes the store; input ready stays low until it ends.
// Registers may be written during the pass.
module ring_foam_decay_diffusion_unit #(
  parameter int MAX_CELLS = rfd_pkg::MAX_CELLS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rfd_fold_if.sink                   in_i,
  rfd_foam_if.source                 out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rfd_pkg::APB_AW-1:0] paddr,
  input  logic [rfd_pkg::APB_DW-1:0] pwdata,
  output logic [rfd_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import rfd_pkg::*;

  localparam int IW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int NW = $clog2(MAX_CELLS + 1);
  localparam logic [31:0] MaxCells32 = 32'(MAX_CELLS);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_LOAD2, S_MIX, S_RET, S_DONE} state_e;

  rfd_cfg_t cfg;
  state_e   state_q;

  logic           store_busy;
  logic [IW-1:0]  rd_a_addr, rd_b_addr, wr_addr;
  logic           wr_en;
  logic [Q_W-1:0] wr_data, rd_a_data, rd_b_data;

  // Control registers
  logic           out_valid_q, send_q;
  logic [Q_W-1:0] foam_q, old_first_q, old_left_q;
  logic [IDX_W-1:0] idx_q;
  logic [IW-1:0]  pos_q, p_q;
  logic           last_q, first_q, single_q, wrap2_q;

  // Datapath registers
  logic [EXC_W-1:0]        excess_q;
  logic [EXC_W+SPAN_W-1:0] prod_g_q;
  logic [Q_W-1:0]          prev_q, left_q, right_q;
  logic [2*Q_W-1:0]        p1_q, p2_q, prod_r_q;
  logic [GEN_W-1:0]        gen_q;

  // Combinational
  logic [31:0]      n_wide;
  logic [NW-1:0]    n_eff;
  logic [IW-1:0]    p_eff, p_next, n_last_addr;
  logic             last_c, first_c, single_c, wrap2_c;
  logic [EXC_W-1:0] fold_pos, thr_ext, excess_c;
  logic [Q_W-1:0]   nb_c, mean_c, w_c, inv_w_c, cand_c, ret_c, blended_c, result_c;
  logic [Q_W:0]     nsum_c;
  logic [Q_W+GAIN_W-1:0] gprod_c;
  logic [2*Q_W:0]   bsum_c;
  logic [GEN_W:0]   rsum_c;
  logic             in_beat, out_free;

  rfd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rfd_store #(.MAX_CELLS(MAX_CELLS), .IW(IW)) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_a_addr_i (rd_a_addr),
    .rd_b_addr_i (rd_b_addr),
    .rd_a_data_o (rd_a_data),
    .rd_b_data_o (rd_b_data),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .busy_o      (store_busy)
  );

  // Ring size in use, saturated to one..MAX_CELLS
  always_comb begin
    if (cfg.ring_length == '0) begin
      n_wide = 32'd1;
    end else if (32'(cfg.ring_length) > MaxCells32) begin
      n_wide = MaxCells32;
    end else begin
      n_wide = 32'(cfg.ring_length);
    end
  end
  assign n_eff = NW'(n_wide);

  // Position, wrapped when the ring has shrunk below it
  assign p_eff       = (32'(pos_q) >= 32'(n_eff)) ? '0 : pos_q;
  assign p_next      = p_eff + IW'(1);
  assign n_last_addr = IW'(32'(n_eff) - 32'd1);
  assign last_c      = (32'(p_eff) == 32'(n_eff) - 32'd1);
  assign first_c     = (p_eff == '0);
  assign single_c    = (32'(n_eff) == 32'd1);
  assign wrap2_c     = first_c && (32'(n_eff) > 32'd2);

  // Store addresses: own cell on port A, neighbor on port B
  assign rd_a_addr = p_eff;
  assign rd_b_addr = (state_q == S_LOAD) ? IW'(1) : (first_c ? n_last_addr : p_next);

  // Excess of the fold over the threshold, negative folds count as zero
  assign fold_pos = in_i.fold[FOLD_W-1] ? '0 : in_i.fold[FOLD_W-2:0];
  assign thr_ext  = EXC_W'(cfg.gen_threshold);
  assign excess_c = (fold_pos > thr_ext) ? fold_pos - thr_ext : '0;

  // Blend, mean and generation terms
  assign nb_c    = clamp_q16(64'(rd_b_data));
  assign nsum_c  = {1'b0, left_q} + {1'b0, right_q};
  assign mean_c  = single_q ? prev_q : nsum_c[Q_W:1];
  assign w_c     = (cfg.blend > ONE_Q16) ? ONE_Q16 : cfg.blend;
  assign inv_w_c = ONE_Q16 - w_c;
  assign cand_c  = clamp_q16(64'(prod_g_q >> 16));
  assign gprod_c = (Q_W+GAIN_W)'(cand_c) * (Q_W+GAIN_W)'(cfg.gen_gain);
  assign ret_c   = (cfg.retention > ONE_Q16) ? ONE_Q16 : cfg.retention;
  assign bsum_c  = {1'b0, p1_q} + {1'b0, p2_q};
  assign blended_c = bsum_c[Q_W+15:16];
  assign rsum_c  = (GEN_W+1)'(prod_r_q[2*Q_W-1:16]) + (GEN_W+1)'(gen_q);
  assign result_c = clamp_q16(64'(rsum_c));

  assign in_beat  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // Write back the new level as the result beat loads
  assign wr_en   = (state_q == S_DONE) && out_free;
  assign wr_addr = p_q;
  assign wr_data = result_c;

  assign in_i.ready       = (state_q == S_IDLE) && !store_busy;
  assign out_o.valid      = out_valid_q;
  assign out_o.foam       = foam_q;
  assign out_o.cell_index = idx_q;
  assign out_o.sweep_end  = send_q;

  // Sequencer, ring latches and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      foam_q      <= '0;
      idx_q       <= '0;
      send_q      <= 1'b0;
      pos_q       <= '0;
      old_first_q <= '0;
      old_left_q  <= '0;
      p_q         <= '0;
      last_q      <= 1'b0;
      first_q     <= 1'b0;
      single_q    <= 1'b0;
      wrap2_q     <= 1'b0;
    end else begin
      // Drop the beat once taken, unless a new one loads in its place
      if (out_valid_q && out_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            p_q      <= p_eff;
            last_q   <= last_c;
            first_q  <= first_c;
            single_q <= single_c;
            wrap2_q  <= wrap2_c;
            state_q  <= S_LOAD;
          end
        end
        S_LOAD:  state_q <= wrap2_q ? S_LOAD2 : S_MIX;
        S_LOAD2: state_q <= S_MIX;
        S_MIX:   state_q <= S_RET;
        S_RET:   state_q <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            foam_q      <= result_c;
            idx_q       <= IDX_W'(32'(p_q));
            send_q      <= last_q;
            if (first_q) begin
              old_first_q <= prev_q;
            end
            old_left_q <= prev_q;
            pos_q      <= last_q ? '0 : p_q + IW'(1);
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath: multiply steps in the load, mix and retention states
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      excess_q <= excess_c;
    end
    if (state_q == S_LOAD) begin
      prev_q   <= clamp_q16(64'(rd_a_data));
      prod_g_q <= (EXC_W+SPAN_W)'(excess_q) * (EXC_W+SPAN_W)'(cfg.inv_span);
      if (first_q) begin
        left_q  <= nb_c;
        right_q <= nb_c;
      end else begin
        left_q  <= old_left_q;
        right_q <= last_q ? old_first_q : nb_c;
      end
    end
    if (state_q == S_LOAD2) begin
      right_q <= nb_c;
    end
    if (state_q == S_MIX) begin
      p1_q  <= (2*Q_W)'(prev_q) * (2*Q_W)'(inv_w_c);
      p2_q  <= (2*Q_W)'(mean_c) * (2*Q_W)'(w_c);
      gen_q <= gprod_c[Q_W+GAIN_W-1:16];
    end
    if (state_q == S_RET) begin
      prod_r_q <= (2*Q_W)'(blended_c) * (2*Q_W)'(ret_c);
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_busy |-> !in_i.ready)
    else $error("input accepted during clearing pass");

  a_write_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> out_o.valid)
    else $error("store write without a result beat");

  a_foam_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.foam <= ONE_Q16))
    else $error("foam level above one");

  a_single_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && single_q) |-> (last_q && first_q))
    else $error("single cell ring not first and last");

endmodule
